[sv/pcm_fifo_player_with_smoothing_macros.svh]
// Assertion macros used by the PCM FIFO player core.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef PCM_FIFO_PLAYER_WITH_SMOOTHING_MACROS_SVH
`define PCM_FIFO_PLAYER_WITH_SMOOTHING_MACROS_SVH

// Checked on every edge outside reset.
`define PFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define PFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

[sv/pfp_pkg.sv]
// Shared types and constants of the PCM FIFO player.
// No dependencies.
package pfp_pkg;

  localparam int DefFifoDepth = 1024;
  localparam int DefRepeat    = 8;

  localparam int ByteW    = 8;
  localparam int SampleW  = 16;
  localparam int FillW    = 11;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 1;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgDampen = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPaused = 1'b1;

  // Item opcodes
  localparam logic OpPush = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      dropped;
    logic [FillW-1:0]          fill;
  } res_t;

endpackage

[sv/pfp_sample_ram.sv]
// Sample store: one write port, one registered read port, with a bypass
// for a write to the address read in the same cycle. Uses pfp_pkg.
module pfp_sample_ram
  import pfp_pkg::*;
#(
  parameter int Depth = DefFifoDepth,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [ByteW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem_q [Depth];
  logic [ByteW-1:0] rdata_q;
  logic [ByteW-1:0] fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q    <= mem_q[raddr_i];
    fwd_data_q <= wdata_i;
  end

  // remember a read that collided with a write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

[sv/pfp_core.sv]
// FIFO control, repeat counter, smoothing filter and mixer.
// Uses pfp_pkg, pfp_sample_ram and the assertion macros.
`include "pcm_fifo_player_with_smoothing_macros.svh"

module pfp_core
  import pfp_pkg::*;
#(
  parameter int FifoDepth = DefFifoDepth,
  parameter int Repeat    = DefRepeat
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      opcode_i,
  input  logic [ByteW-1:0]          pcm_byte_i,
  input  logic signed [SampleW-1:0] mix_in_i,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  output res_t                      res_o
);

  localparam int AddrW = $clog2(FifoDepth);
  localparam int CntW  = $clog2(FifoDepth + 1);
  localparam int HoldW = (Repeat > 1) ? $clog2(Repeat) : 1;

  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic signed [SampleW-1:0] filt_q, filt_d;
  logic dampen_q, paused_q;

  logic [ByteW-1:0] head;
  logic full, empty, do_write, tick_live, play, pop;
  logic signed [SampleW-1:0] s_cen, filt_new, add_val, mix_sum;
  logic signed [18:0] sum_w, sum_adj;

  pfp_sample_ram #(
    .Depth(FifoDepth),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (do_write),
    .waddr_i(wr_ptr_q),
    .wdata_i(pcm_byte_i),
    .raddr_i(rd_ptr_d),
    .rdata_o(head)
  );

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] p);
    ptr_inc = (p == AddrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_q == CntW'(FifoDepth));
  assign empty     = (count_q == '0);
  assign do_write  = accept_i && (opcode_i == OpPush) && !full;
  assign tick_live = accept_i && (opcode_i == OpTick) && !paused_q;
  assign play      = tick_live && !empty;
  assign pop       = play && (hold_q == HoldW'(Repeat - 1));

  // centre the byte: (byte - 128) * 256
  assign s_cen = {~head[ByteW-1], head[ByteW-2:0], 8'h00};

  // d = (s + 3d) / 4, quotient truncated toward zero
  assign sum_w    = $signed({{3{s_cen[15]}}, s_cen})
                  + $signed({{3{filt_q[15]}}, filt_q})
                  + $signed({{2{filt_q[15]}}, filt_q, 1'b0});
  assign sum_adj  = sum_w + (sum_w[18] ? 19'sd3 : 19'sd0);
  assign filt_new = sum_adj[17:2];

  assign add_val = dampen_q ? filt_new : s_cen;
  assign mix_sum = mix_in_i + add_val;

  always_comb begin
    wr_ptr_d = do_write ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_write) begin
      count_d = count_q + 1'b1;
    end else if (pop) begin
      count_d = count_q - 1'b1;
    end
    hold_d = hold_q;
    filt_d = filt_q;
    if (play) begin
      hold_d = pop ? '0 : hold_q + 1'b1;
      if (dampen_q) begin
        filt_d = filt_new;
      end
    end else if (tick_live) begin
      // empty FIFO: restart repeat and filter
      hold_d = '0;
      filt_d = '0;
    end
  end

  always_comb begin
    res_o.dropped = accept_i && (opcode_i == OpPush) && full;
    res_o.fill    = FillW'(count_d);
    if (play) begin
      res_o.sample = mix_sum;
    end else if (tick_live) begin
      res_o.sample = mix_in_i;
    end else begin
      res_o.sample = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      hold_q   <= '0;
      filt_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      hold_q   <= hold_d;
      filt_q   <= filt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dampen_q <= 1'b1;
      paused_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgDampen: dampen_q <= cfg_wdata_i[0];
        CfgPaused: paused_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  `PFP_ASSERT(a_count_bound, count_q <= CntW'(FifoDepth), "FIFO count beyond depth")
  `PFP_ASSERT(a_hold_needs_data, hold_q != '0 |-> !empty, "repeat count held with empty FIFO")
  `PFP_ASSERT(a_ptrs_meet, (empty || full) |-> wr_ptr_q == rd_ptr_q, "pointers disagree with count")

endmodule

[sv/pfp_out_buf.sv]
// Output register with a skid stage, so a new item can be taken while a
// result waits. Uses pfp_pkg.
module pfp_out_buf
  import pfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d, skid_q, skid_d;
  logic out_xfer;

  assign out_xfer = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (load_i) begin
      if (!out_valid_q || out_xfer) begin
        out_d       = res_i;
        out_valid_d = 1'b1;
      end else begin
        // park the result behind the one waiting
        skid_d       = res_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

[sv/pcm_fifo_player_with_smoothing.sv]
// PCM FIFO player with one-pole smoothing: top level.
// Results go to the output register, or to the skid register while the output stalls.
// Throughput: one item per cycle unless stalled; the byte store is read a step ahead.
// Reset clears pointers, count, repeat and filter state and loads the registers
// (smoothing on, not paused); the byte store itself is not cleared.
// Uses pfp_pkg, pfp_core and pfp_out_buf.
module pcm_fifo_player_with_smoothing
  import pfp_pkg::*;
#(
  parameter int FifoDepth = DefFifoDepth,
  parameter int Repeat    = DefRepeat
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      opcode_i,
  input  logic [ByteW-1:0]          pcm_byte_i,
  input  logic signed [SampleW-1:0] mix_in_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic                      dropped_o,
  output logic [FillW-1:0]          fill_level_o,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i
);

  logic accept;
  res_t res, res_out;

  assign accept = in_valid_i && !in_stall_o;

  pfp_core #(
    .FifoDepth(FifoDepth),
    .Repeat   (Repeat)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .opcode_i   (opcode_i),
    .pcm_byte_i (pcm_byte_i),
    .mix_in_i   (mix_in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res)
  );

  pfp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .res_i      (res),
    .full_o     (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_o      (res_out)
  );

  assign sample_out_o = res_out.sample;
  assign dropped_o    = res_out.dropped;
  assign fill_level_o = res_out.fill;

endmodule

[verif/tb_pcm_fifo_player_with_smoothing.sv]
// Self-checking testbench for pcm_fifo_player_with_smoothing: drives push and tick items
// with bursts and output stalls, predicts every result and compares it field by field.
// Depends on pfp_pkg and the block's RTL.
module tb_pcm_fifo_player_with_smoothing;
  import pfp_pkg::*;

  localparam int WatchdogLimit = 2000;

  // Tracks FIFO, repeat and filter state and queues the samples the block should return.
  class pcm_mix_tracker;
    logic [ByteW-1:0] byte_store [DefFifoDepth];
    int unsigned      wr_ptr, rd_ptr, byte_cnt, hold_cnt;
    int               filt;
    logic             dampen, paused;
    res_t             expected_samples[$];
    int               errors, checked, pushes, drops, data_ticks, paused_ticks, empty_ticks;

    function new();
      wr_ptr = 0; rd_ptr = 0; byte_cnt = 0; hold_cnt = 0; filt = 0;
      dampen = 1'b1; paused = 1'b0;
      errors = 0; checked = 0; pushes = 0; drops = 0;
      data_ticks = 0; paused_ticks = 0; empty_ticks = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgDampen) dampen = data[0];
      else if (idx == CfgPaused) paused = data[0];
    endfunction

    function void note_item(logic op, logic [ByteW-1:0] pcm, logic signed [SampleW-1:0] mix);
      res_t r;
      int   centred, add;
      r = '0;
      if (op == OpPush) begin
        pushes++;
        if (byte_cnt >= DefFifoDepth) begin
          r.dropped = 1'b1;
          drops++;
        end else begin
          byte_store[wr_ptr] = pcm;
          wr_ptr = (wr_ptr + 1) % DefFifoDepth;
          byte_cnt++;
        end
      end else if (paused) begin
        paused_ticks++;
      end else if (byte_cnt > 0) begin
        data_ticks++;
        centred = (int'(byte_store[rd_ptr]) - 128) * 256;
        if (dampen) begin
          // signed division truncates toward zero
          filt = (centred + 3 * filt) / 4;
          add  = filt;
        end else begin
          add = centred;
        end
        r.sample = SampleW'(mix + add);
        hold_cnt++;
        if (hold_cnt >= DefRepeat) begin
          hold_cnt = 0;
          rd_ptr   = (rd_ptr + 1) % DefFifoDepth;
          byte_cnt--;
        end
      end else begin
        empty_ticks++;
        hold_cnt = 0;
        filt     = 0;
        r.sample = mix;
      end
      r.fill = FillW'(byte_cnt);
      expected_samples.push_back(r);
    endfunction

    function void check_sample(logic signed [SampleW-1:0] sample, logic dropped,
                               logic [FillW-1:0] fill);
      res_t e;
      if (expected_samples.size() == 0) begin
        errors++;
        $error("result with nothing expected: sample %0d dropped %0b fill %0d",
               sample, dropped, fill);
        return;
      end
      e = expected_samples.pop_front();
      checked++;
      if (sample !== e.sample) begin
        errors++;
        $error("sample_out: expected %0d, actual %0d", e.sample, sample);
      end
      if (dropped !== e.dropped) begin
        errors++;
        $error("dropped: expected %0b, actual %0b", e.dropped, dropped);
      end
      if (fill !== e.fill) begin
        errors++;
        $error("fill_level: expected %0d, actual %0d", e.fill, fill);
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic                      opcode_i    = OpPush;
  logic [ByteW-1:0]          pcm_byte_i  = '0;
  logic signed [SampleW-1:0] mix_in_i    = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      dropped_o;
  logic [FillW-1:0]          fill_level_o;
  logic                      cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CfgDataW-1:0]       cfg_wdata_i = '0;

  pcm_mix_tracker mix_sb = new();

  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_span  = 0;
  int stall_tick  = 0;
  int idle_cycles = 0;

  pcm_fifo_player_with_smoothing u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .opcode_i, .pcm_byte_i, .mix_in_i,
    .out_valid_o, .out_stall_i, .sample_out_o, .dropped_o, .fill_level_o,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Note inputs before checking results so every result still finds its entry.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) mix_sb.write_reg(cfg_index_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_o) mix_sb.note_item(opcode_i, pcm_byte_i, mix_in_i);
      if (out_valid_o && !out_stall_i) mix_sb.check_sample(sample_out_o, dropped_o, fill_level_o);
    end
  end

  // Receiver: switch between free-running, light, heavy and periodic stalling.
  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(32, 200);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall_i <= ((stall_tick % 5) < 2);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("pcm_fifo_player_with_smoothing: mismatch");
      $finish;
    end
  end

  // Hold the item until it transfers; open a random gap at the start of each burst.
  task automatic send_item(logic op, logic [ByteW-1:0] pcm, logic signed [SampleW-1:0] mix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    pcm_byte_i <= pcm;
    mix_in_i   <= mix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drain every expected result, then allow the output register to empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (mix_sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_items(int n, int push_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < push_pct)
        send_item(OpPush, ByteW'($urandom), SampleW'($urandom));
      else
        send_item(OpTick, ByteW'($urandom), SampleW'($urandom));
    end
  endtask

  initial begin
    int push_pct [3];
    int top_up;
    push_pct = '{5, 12, 25};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty ticks at the mix extremes, then bytes at the range ends
    send_item(OpTick, 8'h00, 16'sh7FFF);
    send_item(OpTick, 8'hFF, -16'sd32768);
    send_item(OpPush, 8'h00, 16'sh0000);
    send_item(OpPush, 8'hFF, 16'shFFFF);
    send_item(OpPush, 8'h80, 16'sh0000);
    for (int i = 0; i < DefRepeat; i++)
      send_item(OpTick, 8'h00, (i % 2) ? 16'sh7FFF : -16'sd32768);
    for (int i = 0; i < DefRepeat; i++)
      send_item(OpTick, 8'hFF, 16'sh7FFF);
    settle();
    // Paused ticks must return zero and leave the FIFO alone
    write_reg(CfgPaused, 1'b1);
    send_item(OpTick, 8'h00, 16'sh1234);
    send_item(OpPush, 8'h00, 16'sh0000);
    send_item(OpTick, 8'h00, -16'sd1);
    settle();
    write_reg(CfgPaused, 1'b0);
    write_reg(CfgDampen, 1'b0);
    for (int i = 0; i < DefRepeat + 1; i++)
      send_item(OpTick, 8'h00, -16'sd32768);
    settle();

    // Random phases with shifting push density and settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgDampen, CfgDataW'($urandom_range(0, 1)));
      write_reg(CfgPaused, CfgDataW'($urandom_range(0, 3) == 0));
      random_items(24, push_pct[ph % 3]);
      settle();
    end

    // Fill to the brim, then push past it while paused and while playing
    write_reg(CfgPaused, 1'b0);
    write_reg(CfgDampen, 1'b1);
    top_up = DefFifoDepth - int'(mix_sb.byte_cnt) + 3;
    for (int i = 0; i < top_up; i++)
      send_item(OpPush, ByteW'($urandom), SampleW'($urandom));
    settle();
    write_reg(CfgPaused, 1'b1);
    random_items(8, 50);
    settle();
    write_reg(CfgPaused, 1'b0);
    random_items(60, 10);
    settle();

    repeat (8) @(posedge clk_i);
    $display("%0d results checked: %0d pushes (%0d dropped), %0d ticks on data,",
             mix_sb.checked, mix_sb.pushes, mix_sb.drops, mix_sb.data_ticks);
    $display("%0d ticks on an empty FIFO, %0d paused ticks",
             mix_sb.empty_ticks, mix_sb.paused_ticks);
    if (mix_sb.errors == 0 && mix_sb.pending() == 0) begin
      $display("pcm_fifo_player_with_smoothing: match");
    end else begin
      $display("pcm_fifo_player_with_smoothing: mismatch");
    end
    $finish;
  end

endmodule
